/* rtl/srtc_pkg.sv */
// Package: shared types and constants for the serial RTC block.
package srtc_pkg;

  localparam int IoW = 16;

  typedef enum logic [0:0] {
    CMD_IO_WRITE = 1'b0,
    CMD_TICK     = 1'b1
  } cmd_t;

  typedef struct packed {
    logic           command;
    logic [IoW-1:0] io_value;
    logic           low_only;
  } in_item_t;

  typedef struct packed {
    logic [IoW-1:0] io_readback;
  } out_item_t;

  // register groups, selected by command bits 6..4
  localparam logic [2:0] GRP_STATUS1 = 3'd0;
  localparam logic [2:0] GRP_ALARM1  = 3'd1;
  localparam logic [2:0] GRP_DATETIME = 3'd2;
  localparam logic [2:0] GRP_ADJUST  = 3'd3;
  localparam logic [2:0] GRP_STATUS2 = 3'd4;
  localparam logic [2:0] GRP_ALARM2  = 3'd5;
  localparam logic [2:0] GRP_TIME    = 3'd6;

  localparam logic [IoW-1:0] IO_SEL = 16'h0004;
  localparam logic [IoW-1:0] IO_CLK = 16'h0002;
  localparam logic [IoW-1:0] IO_DIR = 16'h0010;

  function automatic logic [7:0] cmd_remap(input logic [3:0] n);
    return {n[0], n[1], n[2], n[3], 4'h6};
  endfunction

  function automatic logic [6:0] bcd_to_bin(input logic [7:0] v);
    return 7'(v[7:4] * 4'd10) + 7'(v[3:0]);
  endfunction

  // v <= 150
  function automatic logic [7:0] bin_to_bcd(input logic [7:0] v);
    logic [3:0] t;
    logic [7:0] r;
    t = 4'((16'(v) * 16'd205) >> 11);
    r = v - 8'(t * 4'd10);
    return {t, r[3:0]};
  endfunction

  function automatic logic [7:0] bcd_step(input logic [7:0] v);
    logic [4:0] lo;
    logic [3:0] hi;
    lo = 5'(v[3:0]) + 5'd1;
    hi = v[7:4];
    if (lo >= 5'd10) begin
      lo = '0;
      hi = hi + 4'd1;
    end
    return {hi, lo[3:0]};
  endfunction

  function automatic logic [7:0] bcd_limit(input logic [7:0] v, input logic [6:0] lo,
                                           input logic [6:0] hi);
    logic [7:0] d;
    d = 8'(v[7:4] * 4'd10) + 8'(v[3:0]);
    if (d < 8'(lo)) d = 8'(lo);
    if (d > 8'(hi)) d = 8'(hi);
    return bin_to_bcd(d);
  endfunction

  function automatic logic [2:0] mod7(input logic [2:0] v);
    return (v == 3'd7) ? 3'd0 : v;
  endfunction

endpackage

/* rtl/srtc_if.sv */
// Valid/ready channel interface carrying one payload.
interface srtc_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/srtc_core.sv */
// RTC state and per-transaction update: serial shifter, register file, clock tick.
module srtc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  srtc_pkg::in_item_t item,
  output logic [15:0]       io_readback
);
  import srtc_pkg::*;

  logic [15:0] io_reg, io_reg_next;
  logic [7:0]  st1, st1_next, st2, st2_next;
  logic [7:0]  dt [7];
  logic [7:0]  dt_next [7];
  logic [7:0]  al1 [3];
  logic [7:0]  al1_next [3];
  logic [7:0]  al2 [3];
  logic [7:0]  al2_next [3];
  logic [7:0]  adj, adj_next, spare, spare_next;
  logic [7:0]  cur_cmd, cur_cmd_next, shift_in, shift_in_next;
  logic [2:0]  in_cnt, in_cnt_next, out_cnt, out_cnt_next, out_idx, out_idx_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [7:0]  rbuf [8];
  logic [7:0]  rbuf_next [8];

  always_comb begin
    logic [15:0] val;
    logic [7:0]  b, cmd, hr, pm, v;
    logic [3:0]  p;
    logic        rd_bit;
    io_reg_next = io_reg; st1_next = st1; st2_next = st2;
    dt_next = dt; al1_next = al1; al2_next = al2;
    adj_next = adj; spare_next = spare; cur_cmd_next = cur_cmd;
    shift_in_next = shift_in; in_cnt_next = in_cnt; out_cnt_next = out_cnt;
    out_idx_next = out_idx; byte_pos_next = byte_pos; rbuf_next = rbuf;
    val = item.io_value;
    b = '0; cmd = '0; hr = '0; pm = '0; v = '0; p = byte_pos; rd_bit = 1'b0;
    if (item.command == CMD_TICK) begin
      dt_next[6] = bcd_step(dt[6]);
      if (dt_next[6] >= 8'h60) begin
        dt_next[6] = '0;
        dt_next[5] = bcd_step(dt[5]);
        if (dt_next[5] >= 8'h60) begin
          dt_next[5] = '0;
          hr = bcd_step({2'b0, dt[4][5:0]});
          pm = {1'b0, dt[4][6], 6'b0};
          if (st1[1]) begin
            if (hr >= 8'h24) begin
              hr = '0;
              dt_next[3] = (dt[3] >= 8'd6) ? 8'(9'(dt[3]) + 9'd1 - 9'd7) : dt[3] + 8'd1;
              dt_next[2] = bcd_step(dt[2]);
            end
          end else if (hr >= 8'h12) begin
            hr = '0;
            pm = pm ^ 8'h40;
          end
          dt_next[4] = hr | pm;
        end
      end
    end else begin
      if (item.low_only) val = {io_reg[15:8], item.io_value[7:0]};
      if ((val & IO_SEL) != 0) begin
        if ((io_reg & IO_SEL) == 0) begin
          shift_in_next = '0; in_cnt_next = '0; byte_pos_next = '0;
          for (int i = 0; i < 8; i++) rbuf_next[i] = '0;
          out_cnt_next = '0; out_idx_next = '0;
        end else if ((val & IO_CLK) == 0) begin
          if ((val & IO_DIR) != 0) begin
            b = shift_in;
            b[in_cnt] = b[in_cnt] | val[0];
            shift_in_next = b;
            in_cnt_next = in_cnt + 3'd1;
            if (in_cnt == 3'd7) begin
              shift_in_next = '0;
              if (byte_pos < 4'd15) byte_pos_next = byte_pos + 4'd1;
              if (byte_pos == 4'd0) begin
                cmd = (b[7:4] == 4'h6) ? cmd_remap(b[3:0]) : b;
                cur_cmd_next = cmd;
                if (cmd[7] && cmd[3:0] == 4'h6) begin
                  case (cmd[6:4])
                    GRP_STATUS1: begin
                      rbuf_next[0] = st1; st1_next = {4'h0, st1[3:0]};
                    end
                    GRP_STATUS2: rbuf_next[0] = st2;
                    GRP_DATETIME: for (int i = 0; i < 7; i++) rbuf_next[i] = dt[i];
                    GRP_TIME: for (int i = 0; i < 3; i++) rbuf_next[i] = dt[i+4];
                    GRP_ALARM1:
                      if (st2[2]) for (int i = 0; i < 3; i++) rbuf_next[i] = al1[i];
                      else rbuf_next[0] = al1[2];
                    GRP_ALARM2: for (int i = 0; i < 3; i++) rbuf_next[i] = al2[i];
                    GRP_ADJUST: rbuf_next[0] = adj;
                    default: rbuf_next[0] = spare;
                  endcase
                end
              end else if (cur_cmd[3:0] == 4'h6) begin
                case (cur_cmd[6:4])
                  GRP_STATUS1:
                    if (p == 4'd1) begin
                      st1_next = b;
                      if (b[1] != st1[1]) begin
                        hr = {2'b0, dt[4][5:0]};
                        if (b[1]) begin
                          if (dt[4][6]) begin
                            hr = hr + 8'h12;
                            if (hr[3:0] >= 4'hA) hr = hr + 8'h06;
                          end
                          hr = bcd_limit(hr, 7'd0, 7'd23);
                          pm = '0;
                        end else begin
                          if (hr >= 8'h12) begin
                            pm = 8'h40;
                            hr = hr - 8'h12;
                            if (hr[3:0] >= 4'hA) hr = hr - 8'h06;
                          end else pm = '0;
                          hr = bcd_limit(hr, 7'd0, 7'd11);
                        end
                        dt_next[4] = hr | {1'b0, (b[1] ? 1'b0 : pm[6]), 6'b0}
                                     | (b[1] ? {1'b0, dt[4][6], 6'b0} : 8'h00);
                      end
                    end
                  GRP_STATUS2: if (p == 4'd1) st2_next = b;
                  GRP_DATETIME, GRP_TIME: begin
                    v = b;
                    if (cur_cmd[6:4] == GRP_TIME) p = (byte_pos <= 4'd3) ? byte_pos + 4'd4
                                                                         : 4'd0;
                    else if (byte_pos > 4'd7) p = 4'd0;
                    case (p)
                      4'd1: dt_next[0] = bcd_limit(v, 7'd0, 7'd99);
                      4'd2: dt_next[1] = bcd_limit(v & 8'h1F, 7'd1, 7'd12);
                      4'd3: dt_next[2] = bcd_limit(v & 8'h3F, 7'd1, 7'd31);
                      4'd4: dt_next[3] = {5'b0, mod7(v[2:0])};
                      4'd5: begin
                        if (st1[1]) begin
                          hr = bcd_limit(v & 8'h3F, 7'd0, 7'd23);
                          pm = (hr >= 8'h12) ? 8'h40 : 8'h00;
                        end else begin
                          hr = bcd_limit(v & 8'h3F, 7'd0, 7'd11);
                          pm = v & 8'h40;
                        end
                        dt_next[4] = hr | pm;
                      end
                      4'd6: dt_next[5] = bcd_limit(v & 8'h7F, 7'd0, 7'd59);
                      4'd7: dt_next[6] = bcd_limit(v & 8'h7F, 7'd0, 7'd59);
                      default: ;
                    endcase
                  end
                  GRP_ALARM1:
                    if (st2[2]) begin
                      if (p >= 4'd1 && p <= 4'd3) al1_next[2'(p - 4'd1)] = b;
                    end else if (p == 4'd1) al1_next[2] = b;
                  GRP_ALARM2: if (p >= 4'd1 && p <= 4'd3) al2_next[2'(p - 4'd1)] = b;
                  GRP_ADJUST: if (p == 4'd1) adj_next = b;
                  default: if (p == 4'd1) spare_next = b;
                endcase
              end
            end
          end else begin
            rd_bit = rbuf[out_idx][out_cnt];
            io_reg_next[0] = rd_bit;
            out_cnt_next = out_cnt + 3'd1;
            if (out_cnt == 3'd7 && out_idx < 3'd7) out_idx_next = out_idx + 3'd1;
          end
        end
      end
      if ((val & IO_DIR) != 0) io_reg_next = val;
      else io_reg_next = {val[15:1], io_reg_next[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      io_reg <= '0; st1 <= 8'h02; st2 <= '0;
      dt[0] <= 8'h26; dt[1] <= 8'h09; dt[2] <= 8'h12; dt[3] <= 8'h06;
      dt[4] <= 8'h12; dt[5] <= '0; dt[6] <= '0;
      for (int i = 0; i < 3; i++) begin
        al1[i] <= '0; al2[i] <= '0;
      end
      adj <= '0; spare <= '0; cur_cmd <= '0; shift_in <= '0;
      in_cnt <= '0; out_cnt <= '0; out_idx <= '0; byte_pos <= '0;
      for (int i = 0; i < 8; i++) rbuf[i] <= '0;
    end else if (step) begin
      io_reg <= io_reg_next; st1 <= st1_next; st2 <= st2_next;
      dt <= dt_next; al1 <= al1_next; al2 <= al2_next;
      adj <= adj_next; spare <= spare_next; cur_cmd <= cur_cmd_next;
      shift_in <= shift_in_next; in_cnt <= in_cnt_next; out_cnt <= out_cnt_next;
      out_idx <= out_idx_next; byte_pos <= byte_pos_next; rbuf <= rbuf_next;
    end
  end

  assign io_readback = io_reg_next;
endmodule

/* rtl/serial_rtc_bcd_clock_top.sv */
// Top level: input register, RTC core and output register.
// Usage: in_ch carries one transaction per item (IO register write or
// one-second tick); out_ch returns the IO register value after that item.
// Pipeline: an accepted input transaction is held in the input register;
// the core result is loaded into the result register once that register is
// free, and is then offered on out_ch.
// Throughput: one item per cycle while out_ch takes results; the core updates
// all RTC state in a single pass of BCD and mux logic between the two registers.
// The input side keeps taking transactions while a result waits, as long
// as the result register or the input register has room; when the
// receiver stalls, both fill and in_ch.ready drops until out_ch drains.
// Reset (rst, synchronous): clears the pipeline valids and loads the RTC
// with its power-on time and 24-hour mode. No clearing pass is needed.
module serial_rtc_bcd_clock_top (
  input logic  clk,
  input logic  rst,
  srtc_if.sink   in_ch,
  srtc_if.source out_ch
);
  import srtc_pkg::*;

  in_item_t    in_q;
  logic        in_vld;
  logic        step;
  logic [15:0] rb;

  // core consumes the input register when the result register is free
  assign step = in_vld && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) in_vld <= 1'b0;
    else if (in_ch.ready) in_vld <= in_ch.valid;
    if (in_ch.valid && in_ch.ready) in_q <= in_ch.data;
  end

  srtc_core u_core (
    .clk(clk), .rst(rst), .step(step), .item(in_q), .io_readback(rb)
  );

  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (step) out_ch.valid <= 1'b1;
    else if (out_ch.ready) out_ch.valid <= 1'b0;
    if (step) out_ch.data.io_readback <= rb;
  end
endmodule

/* rtl/srtc_checker.sv */
// Port-level checker for the serial RTC top, bound to it.
module srtc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
  // a fresh result needs an input transaction accepted into the input register before it
  a_no_ghost: assert property (@(posedge clk) disable iff (rst)
    !out_valid ##1 out_valid |-> $past(in_valid && in_ready, 2)) else $error("ghost");
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid && $past(!rst) && !$past(in_valid) |-> in_ready) else $error("ready");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("reset");
endmodule

bind serial_rtc_bcd_clock_top srtc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_data(out_ch.data.io_readback)
);
